FILE: src/dmvm_pkg.sv
// Shared constants, types and helpers of the dense matrix-vector multiplier.
`default_nettype none
package dmvm_pkg;

	localparam int MAX_SIZE   = 256;
	localparam int ADDR_W     = $clog2(MAX_SIZE);
	localparam int DIM_W      = ADDR_W + 1;
	localparam int SIZE_W     = 9;
	localparam int ELEM_W     = 32;
	localparam int ACC_W      = 64;
	localparam int ROW_IDX_W  = 8;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
	localparam int FRAC_W     = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd8;

	// register index, taken from paddr[2]
	localparam logic REG_SIZE_IN_USE = 1'b0;

	typedef enum logic {
		CMD_VECTOR = 1'b0,
		CMD_MATRIX = 1'b1
	} cmd_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0]    row_result;
		logic        [ROW_IDX_W-1:0] row_index;
		logic                        last_row;
	} rslt_t;

	function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
		lo = -ACC_W'(64'sh0000_0000_8000_0000);
		if (a > hi) begin
			return ELEM_W'(hi);
		end else if (a < lo) begin
			return ELEM_W'(lo);
		end else begin
			return ELEM_W'(a);
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/dmvm_in_if.sv
// Input element channel: command and element value.
`default_nettype none
interface dmvm_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] elem_value;

	modport source (output valid, output command, output elem_value, input ready);
	modport sink   (input valid, input command, input elem_value, output ready);
endinterface
`default_nettype wire

FILE: src/dmvm_out_if.sv
// Row result channel: saturated row sum, row index and last-row flag.
`default_nettype none
interface dmvm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] row_result;
	logic [7:0]  row_index;
	logic        last_row;

	modport source (output valid, output row_result, output row_index, output last_row,
		input ready);
	modport sink   (input valid, input row_result, input row_index, input last_row,
		output ready);
endinterface
`default_nettype wire

FILE: src/dmvm_rslt_fifo.sv
// Result queue between the accumulator and the output channel.
`default_nettype none
module dmvm_rslt_fifo
	import dmvm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire rslt_t                 push_data,
	output logic      [FIFO_CNT_W-1:0] level,
	dmvm_out_if.source                 rslt
);

	rslt_t                 entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	rslt_t                 head;

	assign pop  = rslt.valid && rslt.ready;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign level           = cnt_q;
	assign rslt.valid      = (cnt_q != '0);
	assign rslt.row_result = head.row_result;
	assign rslt.row_index  = head.row_index;
	assign rslt.last_row   = head.last_row;

endmodule
`default_nettype wire

FILE: src/dense_matrix_vector_multiply.sv
// Top level: vector store, multiply-accumulate pipeline and APB register.
//
// Channel  Dir  Payload                               Transfer
// elem     in   command, elem_value (Q16.16)          valid && ready
// rslt     out  row_result, row_index, last_row       valid && ready
// apb      in   size_in_use at byte address 0         psel && penable && pwrite
//
// One element per cycle while elem.ready is high; a row result reaches rslt after the
// row's last element through the store read, multiply and accumulate registers and the result queue.
// The vector store is a single-port-read 256 x 32 memory, no clearing pass.
// elem.ready drops only when the eight-entry result queue plus the items in
// flight would fill it, so rslt stalls never reach elem directly.
`default_nettype none
module dense_matrix_vector_multiply
	import dmvm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	dmvm_in_if.sink                 elem,
	dmvm_out_if.source              rslt
);

	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0]  dim;

	logic [ADDR_W-1:0] col_q;
	logic [ADDR_W-1:0] row_q;
	logic [DIM_W-1:0]  fill_q;
	logic [DIM_W-1:0]  fill_idx;
	logic [ADDR_W-1:0] rd_addr;

	logic              accept;
	logic              is_matrix;
	logic              wr_en;
	logic              row_end;
	logic              row_last;

	logic [ELEM_W-1:0] store_q [MAX_SIZE];

	logic                    vld_s1;
	logic signed [ELEM_W-1:0] x_s1;
	logic signed [ELEM_W-1:0] v_s1;
	logic                    first_s1;
	logic                    end_s1;
	logic [ADDR_W-1:0]       row_s1;
	logic                    last_s1;

	logic                    vld_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] prod;
	logic                    first_s2;
	logic                    end_s2;
	logic [ADDR_W-1:0]       row_s2;
	logic                    last_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic                    emit_s3;
	logic [ADDR_W-1:0]       row_s3;
	logic                    last_s3;

	logic [FIFO_CNT_W-1:0]   level;
	logic [FIFO_CNT_W-1:0]   inflight;
	rslt_t                   push_data;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? PDATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE_IN_USE) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (size_q == '0) begin
			dim = DIM_W'(1);
		end else if (32'(size_q) > MAX_SIZE) begin
			dim = DIM_W'(MAX_SIZE);
		end else begin
			dim = DIM_W'(size_q);
		end
	end

	// admission: queue must hold every result that could still arrive
	assign inflight   = FIFO_CNT_W'(vld_s1) + FIFO_CNT_W'(vld_s2) + FIFO_CNT_W'(emit_s3);
	assign elem.ready = (level + inflight) < FIFO_CNT_W'(FIFO_DEPTH);
	assign accept     = elem.valid && elem.ready;
	assign is_matrix  = (cmd_t'(elem.command) == CMD_MATRIX);
	assign wr_en      = accept && !is_matrix;

	assign fill_idx = (fill_q >= dim) ? '0 : fill_q;
	assign rd_addr  = (DIM_W'(col_q) < dim) ? col_q : ADDR_W'(dim - DIM_W'(1));
	assign row_end  = !(DIM_W'(col_q) + DIM_W'(1) < dim);
	assign row_last = !(DIM_W'(row_q) + DIM_W'(1) < dim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			fill_q  <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			emit_s3 <= 1'b0;
		end else begin
			vld_s1  <= accept && is_matrix;
			vld_s2  <= vld_s1;
			emit_s3 <= vld_s2 && end_s2;
			if (accept) begin
				if (!is_matrix) begin
					fill_q <= fill_idx + DIM_W'(1);
					col_q  <= '0;
					row_q  <= '0;
				end else if (!row_end) begin
					col_q <= col_q + ADDR_W'(1);
				end else begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + ADDR_W'(1);
				end
			end
		end
	end

	// vector store; writes happen at the transfer edge, reads are registered on every clock
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[fill_idx[ADDR_W-1:0]] <= elem.elem_value;
		end
		v_s1 <= store_q[rd_addr];
	end

	always_comb begin
		prod = ACC_W'(x_s1) * ACC_W'(v_s1);
	end

	// round half up to Q48.16 folded into the accumulate as a carry-in
	assign acc_base = first_s2 ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= elem.elem_value;
			first_s1 <= (col_q == '0);
			end_s1   <= row_end;
			row_s1   <= row_q;
			last_s1  <= row_last;
		end
		prod_s2  <= prod;
		first_s2 <= first_s1;
		end_s2   <= end_s1;
		row_s2   <= row_s1;
		last_s2  <= last_s1;
		if (vld_s2) begin
			acc_q   <= acc_base + (prod_s2 >>> FRAC_W) +
				$signed(ACC_W'(prod_s2[FRAC_W-1]));
			row_s3  <= row_s2;
			last_s3 <= last_s2;
		end
	end

	assign push_data.row_result = sat32(acc_q);
	assign push_data.row_index  = ROW_IDX_W'(row_s3);
	assign push_data.last_row   = last_s3;

	dmvm_rslt_fifo u_rslt_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s3),
		.push_data (push_data),
		.level     (level),
		.rslt      (rslt)
	);

endmodule
`default_nettype wire

FILE: test/tb_dense_matrix_vector_multiply.sv
// Testbench of the dense matrix-vector multiplier: predicted row sums checked per transfer.
`timescale 1ns / 100ps
module tb_dense_matrix_vector_multiply
	import dmvm_pkg::*;
();

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 900;
	localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};
	localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_SIZE_IN_USE, 2'b00};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	dmvm_in_if elem_ch ();
	dmvm_out_if rslt_ch ();

	dense_matrix_vector_multiply uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.elem(elem_ch),
		.rslt(rslt_ch)
	);

	// predicted block state
	logic [ELEM_W-1:0] vec_store [MAX_SIZE];
	bit entry_written [MAX_SIZE];
	logic signed [ACC_W-1:0] acc;
	int unsigned col_cnt;
	int unsigned row_cnt;
	int unsigned fill_cnt;
	logic [SIZE_W-1:0] size_reg;

	rslt_t rows_due [$];
	int errors;
	int items_sent;
	int cycles;
	bit gaps_on;
	bit stalls_on;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_dense_matrix_vector_multiply NOT OK");
			$finish;
		end
	end

	function automatic int unsigned dim_now();
		if (size_reg == '0)
			return 1;
		if (size_reg > MAX_SIZE)
			return MAX_SIZE;
		return 32'(size_reg);
	endfunction

	function automatic bit matrix_allowed();
		int unsigned n;
		int unsigned col;
		n = dim_now();
		col = (col_cnt < n) ? col_cnt : n - 1;
		return entry_written[col[ADDR_W-1:0]];
	endfunction

	function automatic void apply_element(cmd_t cmd, logic [ELEM_W-1:0] value);
		int unsigned n;
		int unsigned col;
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] prod;
		rslt_t r;
		n = dim_now();
		if (cmd == CMD_VECTOR) begin
			if (fill_cnt >= n)
				fill_cnt = 0;
			vec_store[fill_cnt[ADDR_W-1:0]] = value;
			entry_written[fill_cnt[ADDR_W-1:0]] = 1'b1;
			fill_cnt++;
			acc = '0;
			col_cnt = 0;
			row_cnt = 0;
			return;
		end
		col = (col_cnt < n) ? col_cnt : n - 1;
		x = {{(ACC_W-ELEM_W){value[ELEM_W-1]}}, value};
		v = {{(ACC_W-ELEM_W){vec_store[col[ADDR_W-1:0]][ELEM_W-1]}},
			vec_store[col[ADDR_W-1:0]]};
		prod = x * v;
		acc = acc + ((prod + 64'sd32768) >>> FRAC_W);
		if (col_cnt + 1 < n) begin
			col_cnt++;
			return;
		end
		if (acc > 64'sd2147483647)
			r.row_result = 32'h7FFF_FFFF;
		else if (acc < -64'sd2147483648)
			r.row_result = 32'h8000_0000;
		else
			r.row_result = acc[ELEM_W-1:0];
		r.row_index = row_cnt[ROW_IDX_W-1:0];
		r.last_row = (row_cnt + 1 >= n);
		rows_due = {rows_due, r};
		row_cnt = r.last_row ? 0 : row_cnt + 1;
		col_cnt = 0;
		acc = '0;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	task automatic send_element(cmd_t cmd, logic [ELEM_W-1:0] value);
		int gap;
		// never read a store entry that has not been written
		if (cmd == CMD_MATRIX && !matrix_allowed())
			cmd = CMD_VECTOR;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				elem_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		elem_ch.valid <= 1'b1;
		elem_ch.command <= cmd;
		elem_ch.elem_value <= value;
		do @(posedge clk); while (!elem_ch.ready);
		apply_element(cmd, value);
		items_sent++;
	endtask

	task automatic hold_until_empty();
		elem_ch.valid <= 1'b0;
		do @(posedge clk); while (rows_due.size() != 0);
	endtask

	task automatic settle();
		hold_until_empty();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr[2] == REG_SIZE_IN_USE)
			size_reg = data[SIZE_W-1:0];
	endtask

	task automatic test_saturation_extremes();
		settle();
		write_reg(SIZE_ADDR, 32'd2);
		send_element(CMD_VECTOR, 32'h8000_0000);
		send_element(CMD_VECTOR, 32'h7FFF_FFFF);
		send_element(CMD_MATRIX, 32'h8000_0000);
		send_element(CMD_MATRIX, 32'h7FFF_FFFF);
		send_element(CMD_MATRIX, 32'h7FFF_FFFF);
		send_element(CMD_MATRIX, 32'h8000_0000);
	endtask

	task automatic test_rounding_and_min_size();
		settle();
		write_reg(SIZE_ADDR, 32'd1);
		send_element(CMD_VECTOR, 32'h0000_8000);
		// half a unit rounds up, minus half rounds to zero
		send_element(CMD_MATRIX, 32'h0000_0001);
		send_element(CMD_MATRIX, 32'hFFFF_FFFF);
		settle();
		write_reg(SIZE_ADDR, 32'd0);
		send_element(CMD_MATRIX, 32'h0001_0000);
	endtask

	task automatic test_vector_reload();
		settle();
		write_reg(SIZE_ADDR, 32'd2);
		send_element(CMD_VECTOR, 32'h0002_0000);
		send_element(CMD_VECTOR, 32'hFFFF_0000);
		send_element(CMD_MATRIX, 32'h0003_0000);
		send_element(CMD_VECTOR, 32'h0001_8000);
		send_element(CMD_MATRIX, 32'h0001_0000);
		send_element(CMD_MATRIX, 32'h0004_0000);
	endtask

	task automatic test_dimension_shrink();
		settle();
		write_reg(SIZE_ADDR, 32'd3);
		send_element(CMD_VECTOR, 32'h0001_0000);
		send_element(CMD_VECTOR, 32'hFFFE_0000);
		send_element(CMD_VECTOR, 32'h0000_4000);
		repeat (5) send_element(CMD_MATRIX, rand_elem());
		settle();
		// column two of three now lies past the end of a row
		write_reg(SIZE_ADDR, 32'd2);
		send_element(CMD_MATRIX, 32'h0002_8000);
	endtask

	task automatic test_unknown_register();
		settle();
		write_reg(UNUSED_ADDR, 32'd5);
		send_element(CMD_MATRIX, 32'h0001_0000);
		send_element(CMD_MATRIX, 32'hFFFF_8000);
	endtask

	task automatic test_full_dimension();
		settle();
		write_reg(SIZE_ADDR, 32'hFFFF_FFFF);
		repeat (MAX_SIZE) send_element(CMD_VECTOR, rand_elem());
		repeat (2 * MAX_SIZE) send_element(CMD_MATRIX, rand_elem());
		settle();
		write_reg(SIZE_ADDR, MAX_SIZE);
		repeat (MAX_SIZE) send_element(CMD_MATRIX, rand_elem());
		settle();
		// row counter already beyond the new last row
		write_reg(SIZE_ADDR, 32'd3);
		repeat (3) send_element(CMD_MATRIX, rand_elem());
	endtask

	task automatic test_random_stream();
		int start;
		int seqs;
		int rows;
		int n;
		int len;
		logic [SIZE_W-1:0] sz;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 19))
				0: sz = 9'd0;
				1: sz = 9'd1;
				2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: sz = SIZE_W'($urandom_range(2, 6));
				14, 15, 16: sz = SIZE_W'($urandom_range(7, 16));
				17: sz = SIZE_W'($urandom_range(17, 40));
				default: sz = SIZE_W'($urandom_range(41, 64));
			endcase
			write_reg(SIZE_ADDR, {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, sz});
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			n = dim_now();
			seqs = $urandom_range(1, 4);
			repeat (seqs) begin
				if ($urandom_range(0, 4) != 0) begin
					repeat (n) send_element(CMD_VECTOR, rand_elem());
					if ($urandom_range(0, 3) == 0)
						hold_until_empty();
					rows = (n <= 8) ? $urandom_range(1, n + 1) : $urandom_range(1, 2);
					len = rows * n;
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(1, len);
					repeat (len) send_element(CMD_MATRIX, rand_elem());
				end else begin
					len = $urandom_range(1, 12);
					repeat (len)
						send_element($urandom_range(0, 1) ? CMD_MATRIX : CMD_VECTOR,
							rand_elem());
				end
			end
		end
	endtask

	// result sink: stall pattern and comparison against the oldest predicted row
	initial begin
		bit stalled;
		int run_left;
		rslt_t due;
		rslt_ch.ready = 1'b0;
		stalled = 1'b0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rslt_ch.valid && rslt_ch.ready) begin
				if (rows_due.size() == 0) begin
					$error("row result %h with no row due", rslt_ch.row_result);
					errors++;
				end else begin
					due = rows_due.pop_front();
					if (rslt_ch.row_result !== due.row_result) begin
						$error("row_result expected %h actual %h",
							due.row_result, rslt_ch.row_result);
						errors++;
					end
					if (rslt_ch.row_index !== due.row_index) begin
						$error("row_index expected %0d actual %0d",
							due.row_index, rslt_ch.row_index);
						errors++;
					end
					if (rslt_ch.last_row !== due.last_row) begin
						$error("last_row expected %b actual %b",
							due.last_row, rslt_ch.last_row);
						errors++;
					end
				end
			end
			if (!stalls_on) begin
				rslt_ch.ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalled = !stalled;
					run_left = stalled ? $urandom_range(1, 16) : $urandom_range(1, 10);
				end
				run_left--;
				rslt_ch.ready <= !stalled;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		elem_ch.valid = 1'b0;
		elem_ch.command = CMD_VECTOR;
		elem_ch.elem_value = '0;
		size_reg = SIZE_RESET;
		acc = '0;
		col_cnt = 0;
		row_cnt = 0;
		fill_cnt = 0;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation_extremes();
		test_rounding_and_min_size();
		gaps_on = 1'b1;
		test_vector_reload();
		test_dimension_shrink();
		test_unknown_register();
		test_full_dimension();
		test_random_stream();
		hold_until_empty();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb_dense_matrix_vector_multiply OK");
		else
			$display("tb_dense_matrix_vector_multiply NOT OK");
		$finish;
	end

endmodule
